// ===== rtl/core/crccp_pkg.sv =====
// Package for the CRC codeword packer: register map, field widths,
// reset values and result limits. No dependencies.
`default_nettype none

package crccp_pkg;

    // Largest generator the datapath is sized for (default).
    localparam int MAX_GEN_BITS_DEF = 17;
    // Most result bytes one input byte may produce, header included.
    localparam int MAX_RESULTS      = 7;

    localparam int GEN_BITS_W = 17;
    localparam int GEN_LEN_W  = 5;
    localparam int TOTAL_W    = 24;
    localparam int BYTE_W     = 8;
    localparam int PAD_W      = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    localparam logic [GEN_BITS_W-1:0] GEN_BITS_RST = GEN_BITS_W'(11);
    localparam logic [GEN_LEN_W-1:0]  GEN_LEN_RST  = GEN_LEN_W'(4);
    localparam logic                  WORD_MODE_RST = 1'b1;
    localparam logic [TOTAL_W-1:0]    TOTAL_RST    = TOTAL_W'(1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GEN_BITS   = 2'd0,
        CFG_GEN_LENGTH = 2'd1,
        CFG_WORD_MODE  = 2'd2,
        CFG_TOTAL      = 2'd3
    } t_cfg_idx;

endpackage : crccp_pkg

`default_nettype wire

// ===== rtl/core/crccp_encoder.sv =====
// Combinational CRC encoder: turns one input byte into one or two codewords
// concatenated MSB first, plus the leading padding count. Uses crccp_pkg.
`default_nettype none

module crccp_encoder #(
    parameter int MAX_GEN_BITS = crccp_pkg::MAX_GEN_BITS_DEF
) (
    input  wire logic [crccp_pkg::BYTE_W-1:0]     i_data,
    input  wire logic [crccp_pkg::GEN_BITS_W-1:0] i_gen_bits,
    input  wire logic [crccp_pkg::GEN_LEN_W-1:0]  i_gen_length,
    input  wire logic                             i_word_mode,
    input  wire logic [crccp_pkg::PAD_W-1:0]      i_total_low,
    output logic [2*MAX_GEN_BITS+5:0]             o_val,
    output logic [$clog2(2*MAX_GEN_BITS+7)-1:0]   o_nbits,
    output logic [crccp_pkg::PAD_W-1:0]           o_pad
);
    import crccp_pkg::*;

    localparam int LEN_W = $clog2(MAX_GEN_BITS + 1);
    localparam int CW    = MAX_GEN_BITS + 7;
    localparam int W_VAL = 2 * MAX_GEN_BITS + 6;
    localparam int NB_W  = $clog2(W_VAL + 1);

    logic [LEN_W-1:0]                       eff_len;
    logic [MAX_GEN_BITS+GEN_BITS_W-1:0]     gen_wide;
    logic [MAX_GEN_BITS-1:0]                gen;
    logic [NB_W-1:0]                        csz;
    logic [CW-1:0]                          cw_hi;
    logic [CW-1:0]                          cw_lo;
    logic [CW-1:0]                          cw_byte;
    logic [PAD_W-1:0]                       dmod;
    logic [2*PAD_W-1:0]                     prod;

    // Mod-2 long division, one dataword bit a step (at most eight steps).
    function automatic logic [CW-1:0] f_codeword(
        input logic [BYTE_W-1:0]       data,
        input logic                    wide,
        input logic [LEN_W-1:0]        len,
        input logic [MAX_GEN_BITS-1:0] g
    );
        logic [CW-1:0] rem;
        logic [CW-1:0] gw;
        int            dwn;
        int            p;
        dwn = wide ? 8 : 4;
        gw  = CW'(g);
        rem = CW'(data) << (len - LEN_W'(1));
        for (int i = 0; i < 8; i++) begin
            if (i < dwn) begin
                p = dwn - 1 - i + int'(len) - 1;
                if (rem[p]) begin
                    rem = rem ^ (gw << (dwn - 1 - i));
                end
            end
        end
        return (CW'(data) << (len - LEN_W'(1)))
             | (rem & ~({CW{1'b1}} << (len - LEN_W'(1))));
    endfunction

    // Clamp the length: zero acts as one, oversize saturates.
    always_comb begin
        if (i_gen_length == '0) begin
            eff_len = LEN_W'(1);
        end else if (32'(i_gen_length) > 32'(MAX_GEN_BITS)) begin
            eff_len = LEN_W'(MAX_GEN_BITS);
        end else begin
            eff_len = LEN_W'(i_gen_length);
        end
    end

    assign gen_wide = {{MAX_GEN_BITS{1'b0}}, i_gen_bits};
    assign gen      = gen_wide[MAX_GEN_BITS-1:0]
                    & ~({MAX_GEN_BITS{1'b1}} << eff_len);

    assign csz = NB_W'(eff_len) + (i_word_mode ? NB_W'(7) : NB_W'(3));

    assign cw_byte = f_codeword(i_data, 1'b1, eff_len, gen);
    assign cw_hi   = f_codeword({4'b0, i_data[7:4]}, 1'b0, eff_len, gen);
    assign cw_lo   = f_codeword({4'b0, i_data[3:0]}, 1'b0, eff_len, gen);

    always_comb begin
        if (i_word_mode) begin
            o_val   = W_VAL'(cw_byte);
            o_nbits = csz;
        end else begin
            o_val   = (W_VAL'(cw_hi) << csz) | W_VAL'(cw_lo);
            o_nbits = csz + csz;
        end
    end

    // Padding = -(dataword count * codeword size) mod 8.
    assign dmod  = i_word_mode ? i_total_low : {i_total_low[1:0], 1'b0};
    assign prod  = dmod * csz[PAD_W-1:0];
    assign o_pad = PAD_W'(3'd0 - prod[PAD_W-1:0]);

endmodule : crccp_encoder

`default_nettype wire

// ===== rtl/core/crc_codeword_packer_unit.sv =====
// Top level of the CRC codeword packer: config registers, encode stage and
// byte packing output stage. Depends on crccp_pkg and crccp_encoder.
`default_nettype none

// CRC codeword packer. Each accepted input byte is split into datawords (two
// nibbles or one byte, per word_mode); each dataword is followed by its
// remainder of mod-2 division by the configured generator, and the codeword
// bits are packed MSB first into output bytes. The very first transaction
// after reset is preceded by a header byte (tuser high) holding the padding
// count P, then P zero bits, so that a stream of total_bytes inputs ends on
// a byte boundary. Leftover bits stay pending for the next input; there is
// no flush. tlast marks the last output byte caused by one input.
// Timing: an input byte is registered after the encoder in the cycle it is
// accepted, and moves into the packing buffer the cycle after, or as the
// previous item's last byte leaves. The output port emits one byte per
// cycle while the receiver holds tready high; an item produces
// floor((pending + P + codeword bits) / 8) bytes, plus one for the header;
// five in nibble mode with a 17-bit generator. Input and output are decoupled
// by the encode register, so a new input is taken while bytes still drain.
// At most MAX_RESULTS bytes per input; further whole bytes are dropped.
// Write configuration only while the block is idle.
module crc_codeword_packer_unit #(
    parameter int MAX_GEN_BITS = crccp_pkg::MAX_GEN_BITS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // config write channel
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [crccp_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [crccp_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // input stream
    input  wire logic                             i_s_tvalid,
    output logic                                  o_s_tready,
    input  wire logic [7:0]                       i_s_tdata,  // [7:0] data_byte
    // output stream
    output logic                                  o_m_tvalid,
    input  wire logic                             i_m_tready,
    output logic [7:0]                            o_m_tdata,  // [7:0] out_byte
    output logic                                  o_m_tuser,  // [0] is_header
    output logic                                  o_m_tlast   // run_last
);
    import crccp_pkg::*;

    localparam int W_VAL  = 2 * MAX_GEN_BITS + 6;
    localparam int NB_W   = $clog2(W_VAL + 1);
    localparam int ACC_W  = W_VAL + 14;
    localparam int CNT_W  = $clog2(ACC_W + 1);
    localparam int NRES_W = $clog2(MAX_RESULTS);

    // configuration registers
    logic [GEN_BITS_W-1:0] r_gen_bits;
    logic [GEN_LEN_W-1:0]  r_gen_length;
    logic                  r_word_mode;
    logic [TOTAL_W-1:0]    r_total;

    // encode stage
    logic                  r_enc_valid;
    logic [W_VAL-1:0]      r_enc_val;
    logic [NB_W-1:0]       r_enc_nbits;
    logic [PAD_W-1:0]      r_enc_pad;
    logic [W_VAL-1:0]      enc_val;
    logic [NB_W-1:0]       enc_nbits;
    logic [PAD_W-1:0]      enc_pad;

    // packing stage
    logic [ACC_W-1:0]      r_acc,      n_acc;
    logic [CNT_W-1:0]      r_cnt,      n_cnt;
    logic                  r_hdr_pend, n_hdr_pend;
    logic                  r_hdr_sent, n_hdr_sent;
    logic [PAD_W-1:0]      r_pad,      n_pad;
    logic [NRES_W-1:0]     r_nres,     n_nres;

    logic                  s_fire;
    logic                  out_fire;
    logic                  out_last;
    logic                  out_idle;
    logic                  at_limit;
    logic                  load;
    logic [CNT_W-1:0]      load_n;
    logic [ACC_W-1:0]      acc_sh;

    assign o_cfg_ready = 1'b1;

    // config register write decode
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gen_bits   <= GEN_BITS_RST;
            r_gen_length <= GEN_LEN_RST;
            r_word_mode  <= WORD_MODE_RST;
            r_total      <= TOTAL_RST;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_GEN_BITS:   r_gen_bits   <= i_cfg_data[GEN_BITS_W-1:0];
                CFG_GEN_LENGTH: r_gen_length <= i_cfg_data[GEN_LEN_W-1:0];
                CFG_WORD_MODE:  r_word_mode  <= i_cfg_data[0];
                CFG_TOTAL:      r_total      <= i_cfg_data[TOTAL_W-1:0];
                default: ;
            endcase
        end
    end

    // Encode the incoming byte straight off the port.
    crccp_encoder #(
        .MAX_GEN_BITS (MAX_GEN_BITS)
    ) u_encoder (
        .i_data       (i_s_tdata),
        .i_gen_bits   (r_gen_bits),
        .i_gen_length (r_gen_length),
        .i_word_mode  (r_word_mode),
        .i_total_low  (r_total[PAD_W-1:0]),
        .o_val        (enc_val),
        .o_nbits      (enc_nbits),
        .o_pad        (enc_pad)
    );

    // Output side: a byte is ready when the header waits or a full byte sits
    // in the buffer.
    assign at_limit   = (r_nres == NRES_W'(MAX_RESULTS - 1));
    assign o_m_tvalid = r_hdr_pend || (r_cnt >= CNT_W'(8));
    assign out_fire   = o_m_tvalid && i_m_tready;
    assign out_idle   = !r_hdr_pend && (r_cnt < CNT_W'(8));
    assign out_last   = at_limit
                     || (r_hdr_pend ? (r_cnt < CNT_W'(8)) : (r_cnt < CNT_W'(16)));

    assign acc_sh    = r_acc >> (r_cnt - CNT_W'(8));
    assign o_m_tdata = r_hdr_pend ? {{(BYTE_W-PAD_W){1'b0}}, r_pad} : acc_sh[7:0];
    assign o_m_tuser = r_hdr_pend;
    assign o_m_tlast = out_last;

    // Move the encoded item into the buffer once the previous one drains.
    assign load       = r_enc_valid && (out_idle || (out_fire && out_last));
    assign o_s_tready = !r_enc_valid || load;
    assign s_fire     = i_s_tvalid && o_s_tready;

    // Padding is added only with the header, as leading zero bits.
    assign load_n = CNT_W'(r_enc_nbits) + (r_hdr_sent ? CNT_W'(0) : CNT_W'(r_enc_pad));

    always_comb begin
        n_acc      = r_acc;
        n_cnt      = r_cnt;
        n_hdr_pend = r_hdr_pend;
        n_hdr_sent = r_hdr_sent;
        n_pad      = r_pad;
        n_nres     = r_nres;
        if (out_fire) begin
            if (r_hdr_pend) begin
                n_hdr_pend = 1'b0;
            end else begin
                // on the last byte also drop any whole bytes past the limit
                n_cnt = out_last ? CNT_W'(r_cnt[2:0]) : r_cnt - CNT_W'(8);
            end
            n_nres = r_nres + NRES_W'(1);
        end
        if (load) begin
            // stale bits above the count are never read, so no masking
            n_acc      = (r_acc << load_n) | ACC_W'(r_enc_val);
            n_cnt      = CNT_W'(r_cnt[2:0]) + load_n;
            n_hdr_pend = !r_hdr_sent;
            n_hdr_sent = 1'b1;
            n_pad      = r_enc_pad;
            n_nres     = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enc_valid <= 1'b0;
            r_cnt       <= '0;
            r_hdr_pend  <= 1'b0;
            r_hdr_sent  <= 1'b0;
            r_nres      <= '0;
        end else begin
            if (s_fire) begin
                r_enc_valid <= 1'b1;
            end else if (load) begin
                r_enc_valid <= 1'b0;
            end
            r_cnt      <= n_cnt;
            r_hdr_pend <= n_hdr_pend;
            r_hdr_sent <= n_hdr_sent;
            r_nres     <= n_nres;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_enc_val   <= enc_val;
            r_enc_nbits <= enc_nbits;
            r_enc_pad   <= enc_pad;
        end
        r_acc <= n_acc;
        r_pad <= n_pad;
    end

    // A new item never lands on top of bytes still owed by the last one.
    a_load_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |-> (out_idle || (out_fire && out_last)))
        else $error("item loaded while output bytes pending");

    // The header is always the first byte of its run.
    a_hdr_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser) |-> (r_nres == '0))
        else $error("header not first in run");

    // Once the header has gone out it never comes back.
    a_hdr_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_hdr_sent && !r_hdr_pend) |=> !r_hdr_pend)
        else $error("header repeated");

    // The per-item byte count stays under the result limit.
    a_nres_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nres <= NRES_W'(MAX_RESULTS - 1))
        else $error("result count overflow");

    // Leftover bits after an item always fit below one byte.
    a_idle_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_fire && out_last && !load) |=> (r_cnt < CNT_W'(8)))
        else $error("whole byte left after last");

endmodule : crc_codeword_packer_unit

`default_nettype wire

// ===== dv/crccp_stream_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for crc_codeword_packer_unit: tracks config writes, predicts the
// output bytes of every accepted input byte and compares them in order.
// Depends on crccp_pkg.
module crccp_stream_checker (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_valid,
    input  wire logic                             i_cfg_ready,
    input  wire logic [crccp_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [crccp_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                             i_s_tvalid,
    input  wire logic                             i_s_tready,
    input  wire logic [7:0]                       i_s_tdata,
    input  wire logic                             i_m_tvalid,
    input  wire logic                             i_m_tready,
    input  wire logic [7:0]                       i_m_tdata,
    input  wire logic                             i_m_tuser,
    input  wire logic                             i_m_tlast,
    output int                                    o_mismatches,
    output int                                    o_owed
);
    import crccp_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic       hdr;
        logic       last;
    } t_out_beat;

    // Mirrored registers
    logic [GEN_BITS_W-1:0] gen_bits;
    logic [GEN_LEN_W-1:0]  gen_len;
    logic                  word_mode;
    logic [TOTAL_W-1:0]    total;

    // Packing state
    logic [6:0] pend_bits;
    int         pend_cnt;
    logic       hdr_sent;

    t_out_beat owed_beats[$];
    t_out_beat item_beats[$];
    int        mismatches = 0;

    assign o_mismatches = mismatches;

    task automatic note_failure(input string msg);
        $display("%0t checker: %s", $time, msg);
        mismatches++;
    endtask

    // Dataword followed by its mod-2 remainder, right aligned.
    function automatic logic [63:0] crc_codeword(input logic [7:0] data, input int dw,
                                                 input int len);
        logic [63:0] gen;
        logic [63:0] rem;
        int          csz;
        csz = dw + len - 1;
        gen = 64'(gen_bits) & ((64'd1 << len) - 64'd1);
        rem = 64'(data) << (len - 1);
        for (int i = 0; i < dw; i++) begin
            if (rem[csz - 1 - i])
                rem ^= gen << (csz - len - i);
        end
        return (64'(data) << (len - 1)) | (rem & ((64'd1 << (len - 1)) - 64'd1));
    endfunction

    // Append n bits MSB first; every completed byte becomes a result, up to MAX_RESULTS per input.
    task automatic pack_bits(input logic [63:0] val, input int n);
        logic [63:0] acc;
        int          cnt;
        t_out_beat   beat;
        acc = 64'(pend_bits);
        cnt = pend_cnt;
        if (n > 0) begin
            acc = (acc << n) | (val & ((64'd1 << n) - 64'd1));
            cnt += n;
        end
        while (cnt >= 8) begin
            beat.data = 8'(acc >> (cnt - 8));
            beat.hdr  = 1'b0;
            beat.last = 1'b0;
            if (item_beats.size() < MAX_RESULTS)
                item_beats.push_back(beat);
            cnt -= 8;
            acc &= (64'd1 << cnt) - 64'd1;
        end
        pend_bits = acc[6:0];
        pend_cnt  = cnt;
    endtask

    task automatic encode_input_byte(input logic [7:0] b);
        int              len;
        int              dw;
        int              csz;
        int              pad;
        longint unsigned dcnt;
        t_out_beat       beat;
        item_beats.delete();
        len = (gen_len == '0) ? 1 :
              (int'(gen_len) > MAX_GEN_BITS_DEF) ? MAX_GEN_BITS_DEF : int'(gen_len);
        dw  = word_mode ? 8 : 4;
        csz = dw + len - 1;
        // Header and leading zero padding go out ahead of the first codeword only.
        if (!hdr_sent) begin
            dcnt = word_mode ? longint'(total) : 2 * longint'(total);
            pad  = int'((8 - ((dcnt % 8) * csz) % 8) % 8);
            beat.data = 8'(pad);
            beat.hdr  = 1'b1;
            beat.last = 1'b0;
            item_beats.push_back(beat);
            pack_bits(64'd0, pad);
            hdr_sent = 1'b1;
        end
        if (word_mode) begin
            pack_bits(crc_codeword(b, 8, len), csz);
        end else begin
            pack_bits(crc_codeword(b >> 4, 4, len), csz);
            pack_bits(crc_codeword(b & 8'h0F, 4, len), csz);
        end
        foreach (item_beats[k]) begin
            beat = item_beats[k];
            beat.last = (k == item_beats.size() - 1);
            owed_beats.push_back(beat);
        end
    endtask

    always @(posedge i_clk) begin
        t_out_beat want;
        if (!i_rst_n) begin
            gen_bits  = GEN_BITS_RST;
            gen_len   = GEN_LEN_RST;
            word_mode = WORD_MODE_RST;
            total     = TOTAL_RST;
            pend_bits = '0;
            pend_cnt  = 0;
            hdr_sent  = 1'b0;
            owed_beats.delete();
        end else begin
            if ((i_cfg_valid & i_cfg_ready) === 1'b1) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_GEN_BITS:   gen_bits  = i_cfg_data[GEN_BITS_W-1:0];
                    CFG_GEN_LENGTH: gen_len   = i_cfg_data[GEN_LEN_W-1:0];
                    CFG_WORD_MODE:  word_mode = i_cfg_data[0];
                    CFG_TOTAL:      total     = i_cfg_data[TOTAL_W-1:0];
                    default: ;
                endcase
            end
            if ((i_s_tvalid & i_s_tready) === 1'b1)
                encode_input_byte(i_s_tdata);
            if ((i_m_tvalid & i_m_tready) === 1'b1) begin
                if (owed_beats.size() == 0) begin
                    note_failure($sformatf("unexpected byte %02h user %b last %b",
                                           i_m_tdata, i_m_tuser, i_m_tlast));
                end else begin
                    want = owed_beats.pop_front();
                    if (i_m_tdata !== want.data)
                        note_failure($sformatf("out_byte %02h, expected %02h",
                                               i_m_tdata, want.data));
                    if (i_m_tuser !== want.hdr)
                        note_failure($sformatf("is_header %b, expected %b on byte %02h",
                                               i_m_tuser, want.hdr, want.data));
                    if (i_m_tlast !== want.last)
                        note_failure($sformatf("run_last %b, expected %b on byte %02h",
                                               i_m_tlast, want.last, want.data));
                end
            end
        end
        o_owed <= owed_beats.size();
    end

endmodule

// ===== dv/tb_crc_codeword_packer_unit.sv =====
`timescale 1ns / 100ps
// Testbench top for crc_codeword_packer_unit: clock, reset, config writes,
// input bytes and receiver back-pressure. Depends on crccp_pkg and
// crccp_stream_checker, which predicts and checks every output byte.
module tb_crc_codeword_packer_unit;
    import crccp_pkg::*;

    localparam int RESET_CYCLES  = 6;
    localparam int HOLD_CYCLES   = 300;     // long receiver hold-off
    localparam int DRAIN_CYCLES  = 20;      // quiet time after the last byte
    localparam int TIMEOUT_NS    = 5_000_000;
    localparam int RAND_PHASES   = 8;
    localparam int PHASE_ITEMS   = 26;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [7:0]            m_tdata;
    logic                  m_tuser;
    logic                  m_tlast;

    int mismatches;
    int owed;

    // Sender idle and receiver stall odds, in percent per cycle.
    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;

    // The stimulus flips hold_flip to request a hold-off; the receiver
    // process notices the change and counts the hold itself.
    logic hold_flip = 1'b0;
    logic hold_seen = 1'b0;
    int   hold_left = 0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    crc_codeword_packer_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),   // [7:0] data_byte
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),   // [7:0] out_byte
        .o_m_tuser   (m_tuser),   // [0] is_header
        .o_m_tlast   (m_tlast)    // run_last
    );

    crccp_stream_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .i_m_tlast    (m_tlast),
        .o_mismatches (mismatches),
        .o_owed       (owed)
    );

    // Receiver: hold tready low for a whole hold-off when one is requested,
    // otherwise stall at random with the current odds.
    always @(posedge clk) begin
        if (hold_seen != hold_flip) begin
            hold_seen <= hold_flip;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready  <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // Offer one register write and wait for its transaction. cfg_valid stays
    // high so back-to-back writes never lower and raise it in one step.
    task automatic cfg_write(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (cfg_ready !== 1'b1);
    endtask

    // Write all four registers. Bits above the generator, length and mode
    // fields are random so that the masking on write gets exercised as well.
    task automatic load_config(input logic [GEN_BITS_W-1:0] gbits,
                               input logic [GEN_LEN_W-1:0] glen,
                               input logic wmode,
                               input logic [TOTAL_W-1:0] total);
        cfg_write(CFG_GEN_BITS, {7'($urandom), gbits});
        cfg_write(CFG_GEN_LENGTH, {19'($urandom), glen});
        cfg_write(CFG_WORD_MODE, {23'($urandom), wmode});
        cfg_write(CFG_TOTAL, total);
        cfg_valid <= 1'b0;
    endtask

    // Offer one input byte, idling first at the current odds. tvalid is left
    // high after the transaction; the next idle cycle or the batch end drops it.
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge clk); while (s_tready !== 1'b1);
    endtask

    task automatic wait_drained();
        do @(posedge clk); while (owed != 0);
    endtask

    // Stop offering and wait until every predicted byte has come out.
    task automatic finish_batch();
        s_tvalid <= 1'b0;
        wait_drained();
    endtask

    // Mostly uniform bytes, with the all-zero and all-one extremes mixed in.
    function automatic logic [7:0] random_byte();
        if ($urandom_range(9) == 0)
            return $urandom_range(1) ? 8'hFF : 8'h00;
        return 8'($urandom);
    endfunction

    task automatic run_phase(input int n_items, input int tx_pct, input int rx_pct,
                             input bit long_hold, input bit mid_pause);
        tx_idle_pct = tx_pct;
        rx_stall_pct <= rx_pct;
        // The sender keeps offering during the hold-off, so the block fills
        // up and must stall its input.
        if (long_hold)
            hold_flip <= ~hold_flip;
        for (int j = 0; j < n_items; j++) begin
            if (mid_pause && j == n_items / 2) begin
                s_tvalid <= 1'b0;
                wait_drained();
            end
            send_byte(random_byte());
        end
        finish_batch();
    endtask

    initial begin
        logic [GEN_LEN_W-1:0] glen;
        logic                 wmode;
        logic [TOTAL_W-1:0]   total;
        int                   tx_pct;
        int                   rx_pct;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: the first byte carries the header. 16-bit generator in
        // nibble mode with three bytes total gives a nonzero padding count.
        load_config(17'h08005, 5'd16, 1'b0, 24'd3);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h80);
        send_byte(8'h01);
        send_byte(8'hA5);
        send_byte(8'h5A);
        finish_batch();

        // Zero length reads as one: no remainder bits, all-zero generator.
        load_config(17'h00000, 5'd0, 1'b1, 24'hFFFFFF);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'h3C);
        finish_batch();

        // Length above the limit saturates; all-one generator, nibble mode
        // gives the most bytes per input.
        load_config(17'h1FFFF, 5'd31, 1'b0, 24'd1);
        send_byte(8'hFF);
        send_byte(8'h81);
        send_byte(8'h00);
        finish_batch();

        // Leading generator bit zero; the set bit above the length is ignored.
        load_config(17'h10007, 5'd8, 1'b1, 24'd7);
        send_byte(8'hC3);
        send_byte(8'h7E);
        finish_batch();

        // Length one in nibble mode: codewords are the bare nibbles.
        load_config(17'h00001, 5'd1, 1'b0, 24'd2);
        send_byte(8'h12);
        send_byte(8'hFE);
        finish_batch();

        // Random phases: new settings each time, cycling through the idle
        // patterns; one phase with a long receiver hold-off, one with a
        // sender pause in the middle.
        for (int k = 0; k < RAND_PHASES; k++) begin
            case (k)
                0: begin glen = 5'd17; wmode = 1'b0; total = 24'hFFFFFF; end
                1: begin glen = 5'd1;  wmode = 1'b1; total = 24'd1;      end
                2: begin glen = 5'd31; wmode = 1'($urandom); total = 24'($urandom); end
                3: begin glen = 5'd0;  wmode = 1'($urandom); total = 24'($urandom); end
                default: begin
                    glen  = 5'($urandom_range(1, 17));
                    wmode = 1'($urandom);
                    total = 24'($urandom);
                end
            endcase
            case (k % 4)
                0:       begin tx_pct = 0;  rx_pct = 0;  end
                1:       begin tx_pct = 82; rx_pct = 0;  end
                2:       begin tx_pct = 0;  rx_pct = 82; end
                default: begin tx_pct = 13; rx_pct = 13; end
            endcase
            load_config(17'($urandom), glen, wmode, total);
            run_phase(PHASE_ITEMS, tx_pct, rx_pct, k == 4, k == 5);
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Watchdog: a hang or a byte that never arrives ends up here.
    initial begin
        #(TIMEOUT_NS);
        $display("TB_ERROR");
        $finish;
    end

endmodule
